/* hdl/lbc_pkg.sv */
// Shared types and codes for the LRU block buffer cache.
`default_nettype none
package lbc_pkg;

  localparam logic [1:0] OP_GET     = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_PIN     = 2'd2;
  localparam logic [1:0] OP_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_UNDER  = 2'd2;
  localparam logic [1:0] ST_OVER   = 2'd3;

  localparam logic [7:0] CNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    UPD_INC   = 2'd0,
    UPD_DEC   = 2'd1,
    UPD_RETAG = 2'd2
  } upd_kind_t;

  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [4:0]  slot;
  } req_t;

  typedef struct packed {
    logic        valid;
    logic        hit_found;
    logic [7:0]  hit_idx;
    logic [7:0]  hit_cnt;
    logic        hit_valid;
    logic        free_found;
    logic [7:0]  free_idx;
    logic [31:0] free_stamp;
    logic [7:0]  sel_cnt;
  } token_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  idx;
    upd_kind_t   kind;
    logic        set_valid;
    logic [31:0] stamp;
  } upd_t;

endpackage
`default_nettype wire

/* hdl/lbc_cell.sv */
// One buffer slot: tag, count, stamp and valid, plus one stage of the search token.
`default_nettype none
module lbc_cell #(
  parameter logic [7:0] IDX = 8'd0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lbc_pkg::req_t   req,
  input  wire lbc_pkg::upd_t   upd,
  input  wire lbc_pkg::token_t tok_in,
  output lbc_pkg::token_t      tok_out
);

  logic [7:0]      tag_dev;
  logic [31:0]     tag_blk;
  logic [7:0]      cnt;
  logic [31:0]     stamp;
  logic            valid;
  lbc_pkg::token_t tok_next;
  logic            match;
  logic            better;

  always_comb begin
    match    = (tag_dev == req.dev) && (tag_blk == req.blk);
    better   = (cnt == 8'd0) && (!tok_in.free_found || (stamp < tok_in.free_stamp));
    tok_next = tok_in;
    if (match && !tok_in.hit_found) begin
      tok_next.hit_found = 1'b1;
      tok_next.hit_idx   = IDX;
      tok_next.hit_cnt   = cnt;
      tok_next.hit_valid = valid;
    end
    if (better) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = IDX;
      tok_next.free_stamp = stamp;
    end
    if ({3'b000, req.slot} == IDX) begin
      tok_next.sel_cnt = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_dev <= 8'hFF;
      tag_blk <= {24'd0, IDX};
      cnt     <= 8'd0;
      stamp   <= 32'd0;
      valid   <= 1'b0;
    end else if (upd.en && (upd.idx == IDX)) begin
      case (upd.kind)
        lbc_pkg::UPD_INC: begin
          cnt <= cnt + 8'd1;
          if (upd.set_valid) begin
            valid <= 1'b1;
          end
        end
        lbc_pkg::UPD_DEC: begin
          cnt <= cnt - 8'd1;
          if (cnt == 8'd1) begin
            stamp <= upd.stamp;
          end
        end
        lbc_pkg::UPD_RETAG: begin
          tag_dev <= req.dev;
          tag_blk <= req.blk;
          cnt     <= 8'd1;
          stamp   <= 32'd0;
          valid   <= 1'b1;
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/lru_block_buffer_cache_unit.sv */
// Top level of the LRU block buffer cache: request control and the row of slot cells.
//
// channel  dir  fields (tdata / tuser)
// s_axis   in   device, block_number, slot / operation
// m_axis   out  slot_out, hit, need_read / status
//
// After a transaction is accepted, the search token walks the cell row one slot per cycle,
// the token leaving the last cell is captured in a register, and the final state decides
// and writes back the slot while the result is loaded. The next input is taken once the
// block is back in idle.
// Reset (rst, synchronous) restores all slot tags and counts at once; no sweep.
// A result waiting on m_tready holds the block in its final cycle; input is taken
// again once that result is loaded into the output register.
`default_nettype none
module lru_block_buffer_cache_unit #(
  parameter int NUM_BUFFERS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // device[7:0], block_number[39:8], slot[44:40], zero
  input  wire logic [1:0]  s_tuser,  // operation[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // slot_out[4:0], hit[5], need_read[6], zero[7]
  output logic [1:0]       m_tuser   // status[1:0]
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t          state;
  state_t          state_next;
  lbc_pkg::req_t   req;
  logic [1:0]      op;
  logic            launch;
  lbc_pkg::token_t fin;
  lbc_pkg::token_t tok [NUM_BUFFERS+1];
  lbc_pkg::upd_t   upd;
  logic [31:0]     release_clock;
  logic            out_free;
  logic            slot_bad;
  logic [7:0]      r_slot;
  logic            r_hit;
  logic            r_nr;
  logic [1:0]      r_st;
  logic            r_upd;
  logic [NUM_BUFFERS-1:0] tok_valids;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign slot_bad = ({4'b0000, req.slot} >= 9'(NUM_BUFFERS));

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = launch;
  end

  for (genvar i = 0; i < NUM_BUFFERS; i++) begin : g_cell
    lbc_cell #(.IDX(8'(i))) u_cell (
      .clk    (clk),
      .rst    (rst),
      .req    (req),
      .upd    (upd),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
    assign tok_valids[i] = tok[i+1].valid;
  end

  always_comb begin
    r_slot = 8'd0;
    r_hit  = 1'b0;
    r_nr   = 1'b0;
    r_st   = lbc_pkg::ST_OK;
    r_upd  = 1'b0;
    upd           = '0;
    upd.kind      = lbc_pkg::UPD_INC;
    upd.stamp     = release_clock + 32'd1;
    if (op == lbc_pkg::OP_GET) begin
      if (fin.hit_found) begin
        r_slot = fin.hit_idx;
        r_hit  = 1'b1;
        if (fin.hit_cnt == lbc_pkg::CNT_MAX) begin
          r_st = lbc_pkg::ST_OVER;
        end else begin
          r_nr          = !fin.hit_valid;
          r_upd         = 1'b1;
          upd.idx       = fin.hit_idx;
          upd.set_valid = 1'b1;
        end
      end else if (fin.free_found) begin
        r_slot   = fin.free_idx;
        r_nr     = 1'b1;
        r_upd    = 1'b1;
        upd.idx  = fin.free_idx;
        upd.kind = lbc_pkg::UPD_RETAG;
      end else begin
        r_st = lbc_pkg::ST_NOFREE;
      end
    end else begin
      r_slot  = {3'b000, req.slot};
      upd.idx = {3'b000, req.slot};
      if (slot_bad) begin
        r_st = lbc_pkg::ST_NOFREE;
      end else if (op == lbc_pkg::OP_PIN) begin
        if (fin.sel_cnt == lbc_pkg::CNT_MAX) begin
          r_st = lbc_pkg::ST_OVER;
        end else begin
          r_upd = 1'b1;
        end
      end else if (fin.sel_cnt == 8'd0) begin
        r_st = lbc_pkg::ST_UNDER;
      end else begin
        r_upd    = 1'b1;
        upd.kind = lbc_pkg::UPD_DEC;
      end
    end
    upd.en = r_upd && (state == S_FIN) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_SCAN;
      S_SCAN: if (tok[NUM_BUFFERS].valid) state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      launch        <= 1'b0;
      m_tvalid      <= 1'b0;
      release_clock <= 32'd0;
    end else begin
      state  <= state_next;
      launch <= s_tvalid && s_tready;
      if (state == S_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (upd.en && upd.kind == lbc_pkg::UPD_DEC && fin.sel_cnt == 8'd1) begin
        release_clock <= release_clock + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.dev  <= s_tdata[7:0];
      req.blk  <= s_tdata[39:8];
      req.slot <= s_tdata[44:40];
      op       <= s_tuser;
    end
    if (state == S_SCAN && tok[NUM_BUFFERS].valid) begin
      fin <= tok[NUM_BUFFERS];
    end
    if (state == S_FIN && out_free) begin
      m_tdata <= {1'b0, r_nr, r_hit, r_slot[4:0]};
      m_tuser <= r_st;
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_valids))
    else $error("more than one search token in the cell row");

  a_idle_no_token: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !launch && (tok_valids == '0))
    else $error("input ready while a search is in flight");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FIN))
    else $error("result loaded outside the final cycle");

  a_clock_step: assert property (@(posedge clk) disable iff (rst)
    (release_clock != $past(release_clock)) |-> (release_clock == $past(release_clock) + 32'd1))
    else $error("release clock moved by more than one");

endmodule
`default_nettype wire
